[rtl/core/stream_substring_replace_defines.svh]
// Assertion macros for the checker file of the substring replacer.
`ifndef STREAM_SUBSTRING_REPLACE_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define SSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define SSR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ssr_pkg.sv]
// Types and constants for the streaming substring replacer.
`default_nettype none

package ssr_pkg;

   localparam int BYTE_W      = 8;
   localparam int RUN_BYTES   = 8;
   localparam int WORD_W      = BYTE_W * RUN_BYTES;
   localparam int LEN_W       = 4;
   localparam int MATCH_CNT_W = 3;
   localparam int LIMIT_W     = 16;
   localparam int CSR_IDX_W   = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = '1;
   localparam logic [LEN_W-1:0]   MLEN_RESET   = LEN_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_BYTES        = 3'd0,
      CSR_MATCH_LENGTH       = 3'd1,
      CSR_REPLACEMENT_BYTES  = 3'd2,
      CSR_REPLACEMENT_LENGTH = 3'd3,
      CSR_REPLACE_LIMIT      = 3'd4
   } csr_index_type;

   // Register file contents plus write strobes that touch engine state.
   typedef struct packed {
      logic [WORD_W-1:0]  match_bytes;
      logic [LEN_W-1:0]   match_length;
      logic [WORD_W-1:0]  replacement_bytes;
      logic [LEN_W-1:0]   replacement_length;
      logic [LIMIT_W-1:0] replace_limit;
      logic               clear_match;
      logic               reload_limit;
      logic [LIMIT_W-1:0] limit_wdata;
   } cfg_type;

   // One run of result bytes caused by one input word.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] bytes;
      logic [LEN_W-1:0]  count;
      logic              present;
      logic              string_end;
   } run_type;

endpackage

`default_nettype wire

[rtl/core/ssr_stream_if.sv]
// Stream channel interfaces: text input and result output.
`default_nettype none

interface ssr_req_if import ssr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              string_end;

   modport source (output valid, text_byte, string_end, input ready);
   modport sink   (input valid, text_byte, string_end, output ready);
endinterface

interface ssr_rsp_if import ssr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] result_byte;
   logic              byte_present;
   logic              run_last;
   logic              string_done;

   modport source (output valid, result_byte, byte_present, run_last, string_done,
                   input ready);
   modport sink   (input valid, result_byte, byte_present, run_last, string_done,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/stream_substring_replace.sv]
// A word's first result is registered in the result register before it is shown.
// Throughput: one word per cycle while each word yields at most one result
//   and rsp_port.ready is high; a word that yields n results (up to 8) holds
//   the input until the single result register has handed out all n bytes.
// Reset (synchronous, active high): clears match progress and the result
//   register, restores register defaults and reloads the replace count.
`default_nettype none

module stream_substring_replace import ssr_pkg::*; #(
   parameter int MAX_MATCH_BYTES   = 8,
   parameter int MAX_REPLACE_BYTES = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ssr_req_if.sink                   req_port,
   ssr_rsp_if.source                 rsp_port,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_write_data
);

   cfg_type cfg;
   run_type run;
   logic    free;
   logic    accept;

   // Register file; match writes drop a partial match, limit writes reload
   // the remaining replace count at once.
   ssr_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // A new word goes in whenever the result register is empty or hands
   // over its last byte in this cycle. Words that yield nothing (a byte
   // absorbed into a partial match) are taken without touching it.
   assign req_port.ready = free;
   assign accept         = req_port.valid && free;

   // Per-word work: compare against the expected match byte, advance or
   // break the match, pick the run (passthrough, replacement, broken prefix
   // plus byte, or end-of-string flush) and its length.
   ssr_match_engine #(
      .MAX_MATCH_BYTES   (MAX_MATCH_BYTES),
      .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .text_byte  (req_port.text_byte),
      .string_end (req_port.string_end),
      .run        (run)
   );

   // Result register: one run, shifted out byte by byte under rsp_port.ready.
   ssr_out_buffer u_out (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .free     (free),
      .rsp_port (rsp_port)
   );

endmodule

`default_nettype wire

[rtl/core/ssr_csr_regs.sv]
// Configuration registers of the substring replacer.
`default_nettype none

module ssr_csr_regs import ssr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_write_data,
   output cfg_type                   cfg
);

   logic [WORD_W-1:0]  match_bytes_ff;
   logic [LEN_W-1:0]   match_length_ff;
   logic [WORD_W-1:0]  repl_bytes_ff;
   logic [LEN_W-1:0]   repl_length_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_bytes_ff  <= '0;
         match_length_ff <= MLEN_RESET;
         repl_bytes_ff   <= '0;
         repl_length_ff  <= '0;
         limit_ff        <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MATCH_BYTES:        match_bytes_ff  <= csr_write_data;
            CSR_MATCH_LENGTH:       match_length_ff <= csr_write_data[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  repl_bytes_ff   <= csr_write_data;
            CSR_REPLACEMENT_LENGTH: repl_length_ff  <= csr_write_data[LEN_W-1:0];
            CSR_REPLACE_LIMIT:      limit_ff        <= csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.match_bytes        = match_bytes_ff;
      cfg.match_length       = match_length_ff;
      cfg.replacement_bytes  = repl_bytes_ff;
      cfg.replacement_length = repl_length_ff;
      cfg.replace_limit      = limit_ff;
      cfg.clear_match        = csr_write_enable &&
                               (csr_index == CSR_MATCH_BYTES ||
                                csr_index == CSR_MATCH_LENGTH);
      cfg.reload_limit       = csr_write_enable && (csr_index == CSR_REPLACE_LIMIT);
      cfg.limit_wdata        = csr_write_data[LIMIT_W-1:0];
   end

endmodule

`default_nettype wire

[rtl/core/ssr_match_engine.sv]
// Match tracking and run building for one input word.
`default_nettype none

module ssr_match_engine import ssr_pkg::*; #(
   parameter int MAX_MATCH_BYTES   = 8,
   parameter int MAX_REPLACE_BYTES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] text_byte,
   input  wire logic              string_end,
   output run_type                run
);

   localparam logic [LEN_W-1:0] MAX_M = LEN_W'(MAX_MATCH_BYTES);
   localparam logic [LEN_W-1:0] MAX_R = LEN_W'(MAX_REPLACE_BYTES);

   logic [MATCH_CNT_W-1:0] matched_ff, matched_in;
   logic [LIMIT_W-1:0]     left_ff, left_in;

   logic [LEN_W-1:0]       mlen, rlen, k_wide, k_inc, count;
   logic [MATCH_CNT_W-1:0] k, k_next;
   logic [BYTE_W-1:0]      exp_byte;
   logic [WORD_W-1:0]      bytes;
   logic                   limit_hit, hit, complete, present;

   always_comb begin
      mlen = cfg.match_length;
      if (mlen == '0)  mlen = LEN_W'(1);
      if (mlen > MAX_M) mlen = MAX_M;
      rlen = cfg.replacement_length;
      if (rlen > MAX_R) rlen = MAX_R;

      k = matched_ff;
      if ({1'b0, k} >= mlen) k = '0;
      k_wide   = {1'b0, k};
      k_inc    = k_wide + LEN_W'(1);
      exp_byte = cfg.match_bytes[k*BYTE_W +: BYTE_W];

      limit_hit = (left_ff == '0);
      hit       = (text_byte == exp_byte);
      complete  = !limit_hit && hit && (k_inc >= mlen);

      bytes   = cfg.match_bytes;
      count   = '0;
      k_next  = '0;
      present = 1'b1;
      if (limit_hit) begin
         bytes = {{(WORD_W-BYTE_W){1'b0}}, text_byte};
         count = LEN_W'(1);
      end else if (complete) begin
         bytes = cfg.replacement_bytes;
         count = rlen;
      end else if (hit) begin
         k_next = k_inc[MATCH_CNT_W-1:0];
      end else begin
         // mismatch: matched prefix then the breaking byte
         for (int i = 0; i < RUN_BYTES; i++) begin
            if (MATCH_CNT_W'(i) == k)
               bytes[i*BYTE_W +: BYTE_W] = text_byte;
            else if (MATCH_CNT_W'(i) > k)
               bytes[i*BYTE_W +: BYTE_W] = '0;
         end
         count = k_inc;
      end

      if (string_end) begin
         // flush a pending partial match, or emit a bare end marker
         if (k_next != '0) count = {1'b0, k_next};
         k_next = '0;
         if (count == '0) begin
            bytes   = '0;
            count   = LEN_W'(1);
            present = 1'b0;
         end
      end

      matched_in = matched_ff;
      left_in    = left_ff;
      if (cfg.clear_match) matched_in = '0;
      if (cfg.reload_limit) begin
         left_in = cfg.limit_wdata;
      end else if (accept) begin
         matched_in = k_next;
         if (string_end)
            left_in = cfg.replace_limit;
         else if (complete && !left_ff[LIMIT_W-1])
            left_in = left_ff - LIMIT_W'(1);
      end

      run.valid      = accept && (count != '0);
      run.bytes      = bytes;
      run.count      = count;
      run.present    = present;
      run.string_end = string_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff <= '0;
         left_ff    <= LIMIT_RESET;
      end else begin
         matched_ff <= matched_in;
         left_ff    <= left_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ssr_out_buffer.sv]
// Result register: holds one run and shifts it out a byte per take.
`default_nettype none

module ssr_out_buffer import ssr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  run_type    run,
   output logic       free,
   ssr_rsp_if.source  rsp_port
);

   logic              busy_ff, busy_in;
   logic [WORD_W-1:0] bytes_ff, bytes_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              present_ff, present_in;
   logic              end_ff, end_in;
   logic              take, last;

   always_comb begin
      take = busy_ff && rsp_port.ready;
      last = (count_ff == LEN_W'(1));
      free = !busy_ff || (take && last);

      busy_in    = busy_ff;
      bytes_in   = bytes_ff;
      count_in   = count_ff;
      present_in = present_ff;
      end_in     = end_ff;
      if (run.valid) begin
         busy_in    = 1'b1;
         bytes_in   = run.bytes;
         count_in   = run.count;
         present_in = run.present;
         end_in     = run.string_end;
      end else if (take) begin
         busy_in  = !last;
         bytes_in = bytes_ff >> BYTE_W;
         count_in = count_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   always_ff @(posedge clock) begin
      bytes_ff   <= bytes_in;
      count_ff   <= count_in;
      present_ff <= present_in;
      end_ff     <= end_in;
   end

   assign rsp_port.valid        = busy_ff;
   assign rsp_port.result_byte  = bytes_ff[BYTE_W-1:0];
   assign rsp_port.byte_present = present_ff;
   assign rsp_port.run_last     = last;
   assign rsp_port.string_done  = last && end_ff;

endmodule

`default_nettype wire

[rtl/core/ssr_checker.sv]
// Port-level checks for the substring replacer, bound to the top level.
`default_nettype none
`include "stream_substring_replace_defines.svh"

module ssr_checker import ssr_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_string_end,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] rsp_result_byte,
   input wire logic              rsp_run_last,
   input wire logic              rsp_string_done
);

   `SSR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_byte) && $stable(rsp_run_last) && $stable(rsp_string_done), "result word changed while stalled")
   `SSR_ASSERT(a_stall_blocks_in, clock, reset, rsp_valid && !rsp_ready |-> !req_ready, "input taken while result stalled")
   `SSR_ASSERT(a_end_gives_result, clock, reset, req_valid && req_ready && req_string_end |=> rsp_valid, "string end gave no result")
   `SSR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .req_string_end  (req_port.string_end),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_result_byte (rsp_port.result_byte),
   .rsp_run_last    (rsp_port.run_last),
   .rsp_string_done (rsp_port.string_done)
);

`default_nettype wire
